FILE: rtl/lste_pkg.sv
// ----------------------------------------------------------------------------
// lste_pkg
// shared widths, constants and the table entry layout of the sieve engine
// ----------------------------------------------------------------------------
package lste_pkg;

    localparam int unsigned MAX_VALUE  = 65535;
    localparam int unsigned MAX_PRIMES = 8192;

    localparam int unsigned VAL_W   = 16;
    localparam int unsigned MOB_W   = 2;
    localparam int unsigned CNT_W   = 14;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned TAB_DEPTH = MAX_VALUE + 1;
    localparam int unsigned PL_AW   = $clog2(MAX_PRIMES);

    // input item kinds
    localparam logic FUNC_BUILD = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_BUILD = 2'd2;

    // mobius codes, two's complement
    localparam logic [MOB_W-1:0] MOB_ONE   = 2'b01;
    localparam logic [MOB_W-1:0] MOB_ZERO  = 2'b00;
    localparam logic [MOB_W-1:0] MOB_MINUS = 2'b11;

    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 56;

    // one row of the value table
    typedef struct packed {
        logic [VAL_W-1:0] factor;
        logic [VAL_W-1:0] totient;
        logic [MOB_W-1:0] mobius;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage

FILE: rtl/lste_ram.sv
// ----------------------------------------------------------------------------
// lste_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lste_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/linear_sieve_table_engine.sv
// ----------------------------------------------------------------------------
// linear_sieve_table_engine
// linear sieve of euler over 0..limit with factor, totient and mobius tables
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                 payload
// s         in   i_s_tvalid / o_s_tready   tdata: query_value, tuser: func
// m         out  o_m_tvalid / i_m_tready   tdata: status .. prime_count
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_data: sieve_limit
//
// a query reads the value table once and its result is then registered,
// and queries stream at one per cycle while the output is taken
// a build clears entries 0..limit, then per value reads its table entry
// (S_RDI, S_WAITI), sets up the prime list read (S_KPRE) and writes one
// prime product per S_KLOOP step, with a closing step unless the loop stops
// on the smallest factor; the registered table read sets this pace
// reset is synchronous active low and clears control state except r_i; the
// tables need no reset since a build writes every entry a query can reach
// a stalled output holds its result; the input stays open until a second
// query result would have nowhere to go
//
module linear_sieve_table_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [lste_pkg::IN_DATA_W-1:0]     i_s_tdata,  // [15:0] query_value
    input  logic                               i_s_tuser,  // [0] func
    // master side
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [1:0] status, [2] prime flag, [18:3] smallest_factor,
    // [34:19] totient, [36:35] mobius_value, [50:37] prime_count, rest zero
    output logic [lste_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // configuration
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lste_pkg::VAL_W-1:0]         i_cfg_data
);

    import lste_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_RDI,
        S_WAITI,
        S_KPRE,
        S_KLOOP,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [VAL_W-1:0]    r_cfg, n_cfg;
    logic [VAL_W-1:0]    r_lim, n_lim;       // limit of the build in progress
    logic [VAL_W-1:0]    r_blim, n_blim;     // limit of the last finished build
    logic                r_built, n_built;
    logic [VAL_W-1:0]    r_i, n_i;
    logic [CNT_W-1:0]    r_k, n_k;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [VAL_W-1:0]    r_f, n_f;           // entry of the current i
    logic [VAL_W-1:0]    r_t, n_t;
    logic [MOB_W-1:0]    r_m, n_m;
    logic                r_qv, n_qv;         // query waiting for its table read
    logic [STAT_W-1:0]   r_qst, n_qst;
    logic [VAL_W-1:0]    r_qval, n_qval;
    logic                r_ov, n_ov;
    logic [OUT_DATA_W-1:0] r_odata, n_odata;

    // ram ports
    logic                ent_we, ent_re;
    logic [VAL_W-1:0]    ent_waddr, ent_raddr;
    t_entry              ent_wdata, ent_rd;
    logic [ENTRY_W-1:0]  ent_rd_bits;
    logic                pl_we;
    logic [PL_AW-1:0]    pl_waddr;
    logic [VAL_W-1:0]    pl_wdata, pl_rd;

    logic                load, s_ready, acc;
    logic                is_new;
    logic [2*VAL_W-1:0]  prod_x, prod_t;
    logic [VAL_W-1:0]    mul_op;
    logic                same, in_range, more;
    logic                q_prime;
    logic [VAL_W-1:0]    q_f, q_t;
    logic [MOB_W-1:0]    q_m;
    logic [CNT_W-1:0]    q_cnt;

    lste_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TAB_DEPTH)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rd_bits)
    );

    lste_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_PRIMES)
    ) u_prime_ram (
        .i_clk   (i_clk),
        .i_we    (pl_we),
        .i_waddr (pl_waddr),
        .i_wdata (pl_wdata),
        .i_re    (1'b1),
        .i_raddr (n_k[PL_AW-1:0]),
        .o_rdata (pl_rd)
    );

    assign ent_rd = t_entry'(ent_rd_bits);

    // handshakes
    assign load       = !r_ov || i_m_tready;
    assign s_ready    = (r_state == S_IDLE) && (!r_qv || load);
    assign acc        = i_s_tvalid && s_ready;
    assign o_s_tready = s_ready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;

    // table read: query address while idle, else the sieve index
    assign ent_re    = (acc && i_s_tuser == FUNC_QUERY) || (r_state == S_RDI);
    assign ent_raddr = (r_state == S_IDLE) ? i_s_tdata[VAL_W-1:0] : r_i;

    // inner step: product i*p and totient update are computed in parallel
    assign is_new   = (ent_rd.factor == '0);
    assign same     = (r_f == pl_rd);
    assign mul_op   = same ? pl_rd : pl_rd - VAL_W'(1);
    assign prod_x   = r_i * pl_rd;
    assign prod_t   = r_t * mul_op;
    assign in_range = (prod_x <= {{VAL_W{1'b0}}, r_lim});
    assign more     = (r_k < r_count);

    // query result fields, all zero on an error status
    assign q_f     = (r_qst == STAT_OK) ? ent_rd.factor : '0;
    assign q_t     = (r_qst == STAT_OK) ? ent_rd.totient : '0;
    assign q_m     = (r_qst == STAT_OK) ? ent_rd.mobius : MOB_ZERO;
    assign q_cnt   = (r_qst == STAT_OK) ? r_count : '0;
    assign q_prime = (r_qst == STAT_OK) && (r_qval >= VAL_W'(2)) && (ent_rd.factor == r_qval);

    always_comb begin
        n_state = r_state;
        n_cfg   = r_cfg;
        n_lim   = r_lim;
        n_blim  = r_blim;
        n_built = r_built;
        n_i     = r_i;
        n_k     = r_k;
        n_count = r_count;
        n_f     = r_f;
        n_t     = r_t;
        n_m     = r_m;
        n_qv    = r_qv;
        n_qst   = r_qst;
        n_qval  = r_qval;
        n_ov    = r_ov;
        n_odata = r_odata;

        ent_we    = 1'b0;
        ent_waddr = r_i;
        ent_wdata = '0;
        pl_we     = 1'b0;
        pl_waddr  = r_count[PL_AW-1:0];
        pl_wdata  = r_i;

        if (i_cfg_valid) begin
            n_cfg = i_cfg_data;
        end

        // output register
        if (r_ov && i_m_tready) begin
            n_ov = 1'b0;
        end
        if (r_qv && load) begin
            n_ov    = 1'b1;
            n_odata = OUT_DATA_W'({q_cnt, q_m, q_t, q_f, q_prime, r_qst});
            n_qv    = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_s_tuser == FUNC_QUERY) begin
                        n_qv   = 1'b1;
                        n_qval = i_s_tdata[VAL_W-1:0];
                        if (!r_built) begin
                            n_qst = STAT_NO_BUILD;
                        end else if (i_s_tdata[VAL_W-1:0] > r_blim) begin
                            n_qst = STAT_RANGE;
                        end else begin
                            n_qst = STAT_OK;
                        end
                    end else begin
                        n_lim   = r_cfg;
                        n_count = '0;
                        n_i     = '0;
                        n_state = S_CLEAR;
                    end
                end
            end
            // clearing sweep, entry one gets its fixed values
            S_CLEAR: begin
                ent_we = 1'b1;
                if (r_i == VAL_W'(1)) begin
                    ent_wdata = '{factor: VAL_W'(1), totient: VAL_W'(1), mobius: MOB_ONE};
                end
                if (r_i == r_lim) begin
                    if (r_lim < VAL_W'(2)) begin
                        n_state = S_DONE;
                    end else begin
                        n_i     = VAL_W'(2);
                        n_state = S_RDI;
                    end
                end else begin
                    n_i = r_i + VAL_W'(1);
                end
            end
            S_RDI: begin
                n_state = S_WAITI;
            end
            // entry of i is back; untouched means prime
            S_WAITI: begin
                if (is_new) begin
                    ent_we    = 1'b1;
                    ent_wdata = '{factor: r_i, totient: r_i - VAL_W'(1), mobius: MOB_MINUS};
                    n_f = r_i;
                    n_t = r_i - VAL_W'(1);
                    n_m = MOB_MINUS;
                    if (r_count < CNT_W'(MAX_PRIMES)) begin
                        pl_we   = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end else begin
                    n_f = ent_rd.factor;
                    n_t = ent_rd.totient;
                    n_m = ent_rd.mobius;
                end
                n_k     = '0;
                n_state = S_KPRE;
            end
            // prime list read of index zero after any append
            S_KPRE: begin
                n_k     = '0;
                n_state = S_KLOOP;
            end
            S_KLOOP: begin
                if (more && in_range) begin
                    ent_we    = 1'b1;
                    ent_waddr = prod_x[VAL_W-1:0];
                    ent_wdata.factor  = pl_rd;
                    ent_wdata.totient = prod_t[VAL_W-1:0];
                    ent_wdata.mobius  = same ? MOB_ZERO : MOB_ZERO - r_m;
                end
                if (more && in_range && !same) begin
                    n_k = r_k + CNT_W'(1);
                end else if (r_i == r_lim) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + VAL_W'(1);
                    n_state = S_RDI;
                end
            end
            S_DONE: begin
                if (load) begin
                    n_ov    = 1'b1;
                    n_odata = OUT_DATA_W'({r_count, MOB_ZERO, {(2*VAL_W+1){1'b0}}, STAT_OK});
                    n_built = 1'b1;
                    n_blim  = r_lim;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= '0;
            r_lim   <= '0;
            r_blim  <= '0;
            r_built <= 1'b0;
            r_count <= '0;
            r_k     <= '0;
            r_qv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cfg   <= n_cfg;
            r_lim   <= n_lim;
            r_blim  <= n_blim;
            r_built <= n_built;
            r_count <= n_count;
            r_k     <= n_k;
            r_qv    <= n_qv;
            r_ov    <= n_ov;
        end
        r_i     <= n_i;
        r_f     <= n_f;
        r_t     <= n_t;
        r_m     <= n_m;
        r_qst   <= n_qst;
        r_qval  <= n_qval;
        r_odata <= n_odata;
    end

endmodule

FILE: dv/tb_linear_sieve_table_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_sieve_table_engine
// self-checking bench: limit writes, table builds and lookups against an
// in-bench sieve, with random idle and stall on both stream sides
// ----------------------------------------------------------------------------
module tb_linear_sieve_table_engine;
    import lste_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              prime_flag;
        logic [VAL_W-1:0]  factor;
        logic [VAL_W-1:0]  totient;
        logic [MOB_W-1:0]  mobius;
        logic [CNT_W-1:0]  count;
    } t_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;  // [15:0] query_value
    logic                  i_s_tuser;  // [0] func
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    // [1:0] status, [2] prime flag, [18:3] smallest_factor,
    // [34:19] totient, [36:35] mobius_value, [50:37] prime_count
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [VAL_W-1:0]      i_cfg_data;

    linear_sieve_table_engine dut (.*);

    // sieve copy held by the bench
    int unsigned spf_tab [0:MAX_VALUE];
    int unsigned phi_tab [0:MAX_VALUE];
    int          mob_tab [0:MAX_VALUE];
    int unsigned prime_tab [0:MAX_PRIMES-1];
    int unsigned n_primes;
    bit          tables_built;
    int unsigned limit_reg;
    int unsigned latched_limit;

    t_result     pending_results[$];
    int unsigned errors;
    int unsigned n_checked;
    int unsigned n_builds;
    int unsigned n_queries;
    int unsigned n_range;
    int unsigned cycles;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // linear sieve over 0..limit_reg, which then becomes latched_limit
    task automatic build_tables();
        int unsigned lim;
        int unsigned x;
        int unsigned p;
        bit          same;
        lim = limit_reg;
        for (int unsigned j = 0; j <= MAX_VALUE; j++) spf_tab[j] = 0;
        n_primes = 0;
        phi_tab[0] = 0;
        mob_tab[0] = 0;
        if (lim >= 1) begin
            spf_tab[1] = 1;
            phi_tab[1] = 1;
            mob_tab[1] = 1;
        end
        for (int unsigned i = 2; i <= lim; i++) begin
            if (spf_tab[i] == 0) begin
                spf_tab[i] = i;
                phi_tab[i] = i - 1;
                mob_tab[i] = -1;
                if (n_primes < MAX_PRIMES) begin
                    prime_tab[n_primes] = i;
                    n_primes++;
                end
            end
            for (int unsigned k = 0; k < n_primes; k++) begin
                p = prime_tab[k];
                x = i * p;
                if (x > lim) break;
                same = (spf_tab[i] == p);
                spf_tab[x] = p;
                if (same) begin
                    phi_tab[x] = phi_tab[i] * p;
                    mob_tab[x] = 0;
                    break;
                end
                phi_tab[x] = phi_tab[i] * (p - 1);
                mob_tab[x] = -mob_tab[i];
            end
        end
        latched_limit = lim;
        tables_built  = 1'b1;
    endtask

    task automatic predict_result(input logic func, input logic [VAL_W-1:0] v);
        t_result r;
        r = '0;
        if (func == FUNC_BUILD) begin
            build_tables();
            r.count = n_primes[CNT_W-1:0];
            n_builds++;
        end else if (!tables_built) begin
            r.status = STAT_NO_BUILD;
        end else if (v > latched_limit) begin
            r.status = STAT_RANGE;
            n_range++;
        end else begin
            r.status     = STAT_OK;
            r.prime_flag = (v >= 2) && (spf_tab[v] == v);
            r.factor     = spf_tab[v][VAL_W-1:0];
            r.totient    = phi_tab[v][VAL_W-1:0];
            r.mobius     = (mob_tab[v] > 0) ? MOB_ONE : (mob_tab[v] < 0) ? MOB_MINUS : MOB_ZERO;
            r.count      = n_primes[CNT_W-1:0];
            n_queries++;
        end
        pending_results.push_back(r);
    endtask

    // one input transfer; valid stays high into the next call when no gap is drawn
    task automatic send_item(input logic func, input logic [VAL_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= v;
        do @(negedge i_clk); while (!o_s_tready);
        @(posedge i_clk);
        predict_result(func, v);
    endtask

    task automatic query(input logic [VAL_W-1:0] v);
        send_item(FUNC_QUERY, v);
    endtask

    task automatic build();
        send_item(FUNC_BUILD, '0);
    endtask

    // wait until every result is back, then let the engine settle
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_limit(input int unsigned lim);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lim[VAL_W-1:0];
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        limit_reg = lim & 16'hFFFF;
    endtask

    task automatic report_mismatch(input string field, input longint got, input longint want);
        errors++;
        $display("[%0t] %s mismatch: got %0h expected %0h", $realtime, field, got, want);
    endtask

    // result checker: a transfer happens at the next rising edge
    always @(negedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status     = o_m_tdata[1:0];
            got.prime_flag = o_m_tdata[2];
            got.factor     = o_m_tdata[18:3];
            got.totient    = o_m_tdata[34:19];
            got.mobius     = o_m_tdata[36:35];
            got.count      = o_m_tdata[50:37];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.status !== want.status) report_mismatch("status", got.status, want.status);
                if (got.prime_flag !== want.prime_flag)
                    report_mismatch("prime_flag", got.prime_flag, want.prime_flag);
                if (got.factor !== want.factor) report_mismatch("factor", got.factor, want.factor);
                if (got.totient !== want.totient)
                    report_mismatch("totient", got.totient, want.totient);
                if (got.mobius !== want.mobius) report_mismatch("mobius", got.mobius, want.mobius);
                if (got.count !== want.count) report_mismatch("count", got.count, want.count);
            end
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ---- tests ----

    task automatic test_before_build();
        query(16'd0);
        query(16'hFFFF);
        query(16'd7);
    endtask

    task automatic test_tiny_limits();
        write_limit(0);
        build();
        query(16'd0);
        query(16'd1);
        write_limit(1);
        build();
        query(16'd0);
        query(16'd1);
        query(16'd2);
        write_limit(2);
        build();
        query(16'd2);
        query(16'd3);
    endtask

    int unsigned int_list_36[8] = '{4, 12, 30, 31, 35, 36, 8, 9};

    task automatic test_latched_limit();
        write_limit(36);
        build();
        write_limit(5);  // no effect until the next build
        foreach (int_list_36[i]) query(int_list_36[i][VAL_W-1:0]);
        query(16'd37);
        build();
        query(16'd6);
        query(16'd5);
    endtask

    task automatic test_full_range();
        write_limit(65535);
        build();
        query(16'hFFFF);
        query(16'd65521);
        query(16'd65534);
        query(16'd32768);
        query(16'd0);
        for (int i = 0; i < 40; i++) query(VAL_W'($urandom_range(0, 65535)));
    endtask

    // random builds and lookups under one idle and stall setting
    task automatic test_random_mix(input int unsigned s_pct, input int unsigned r_pct,
                                   input int unsigned n_items);
        int unsigned lim;
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        for (int unsigned n = 0; n < n_items; n++) begin
            if (n % 80 == 0) begin
                lim = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4000)
                                                  : $urandom_range(0, 400);
                write_limit(lim);
                build();
            end else if ($urandom_range(0, 29) == 0) begin
                build();
            end else if ($urandom_range(0, 9) == 0) begin
                query(VAL_W'($urandom_range(0, 65535)));
            end else begin
                query(VAL_W'($urandom_range(0, latched_limit + 2)));
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = FUNC_QUERY;
        i_m_tready     = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        cycles         = 0;
        errors         = 0;
        n_checked      = 0;
        n_builds       = 0;
        n_queries      = 0;
        n_range        = 0;
        n_primes       = 0;
        tables_built   = 1'b0;
        limit_reg      = 0;
        latched_limit  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_before_build();
        test_tiny_limits();
        test_latched_limit();
        test_random_mix(0, 0, 420);
        test_random_mix(56, 0, 400);
        test_random_mix(0, 56, 400);
        test_random_mix(21, 21, 400);
        test_full_range();

        drain();
        $display("covered %0d builds, %0d in-range lookups, %0d out-of-range lookups",
                 n_builds, n_queries, n_range);
        $display("%0d results checked, %0d mismatches, %0d cycles", n_checked, errors, cycles);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
